### rtl/avr_pkg.sv
package avr_pkg;

  localparam int FIELD_W = 21;
  localparam int CFG_W   = 63;
  localparam int SIZE_FW = 7;
  localparam int COORD_W = 8;
  localparam int INVAL_W = 16;
  localparam int OUT_W   = 24;
  localparam int IDX_W   = 3;
  localparam int PW      = 32;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_STEP_I  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEP_J  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_K  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ORIGIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIZE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_NEAREST = 3'd5;

  localparam logic [CFG_W-1:0]   STEP_I_RST  = 63'd2048;
  localparam logic [CFG_W-1:0]   STEP_J_RST  = 63'd4294967296;
  localparam logic [CFG_W-1:0]   STEP_K_RST  = 63'd9007199254740992;
  localparam logic [3*SIZE_FW-1:0] SIZE_RST  = 21'd1056832;

  typedef enum logic [1:0] {
    K_WRITE,
    K_NEAR,
    K_TRI,
    K_OUT
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WRITE,
    B_READ,
    B_WAIT,
    B_DONE
  } back_state_t;

  function automatic logic signed [FIELD_W-1:0] field_sel(input logic [CFG_W-1:0] r,
                                                         input logic [1:0] ax);
    logic signed [FIELD_W-1:0] f;
    unique case (ax)
      2'd0:    f = r[FIELD_W-1:0];
      2'd1:    f = r[2*FIELD_W-1:FIELD_W];
      2'd2:    f = r[3*FIELD_W-1:2*FIELD_W];
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

### rtl/avr_front.sv
module avr_front
  import avr_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int VOXEL_BITS = 16,
  parameter int FRAC_BITS  = 11,
  parameter int DW         = 6,
  parameter int EW         = 2 + VOXEL_BITS + 3*FRAC_BITS + 3*DW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [COORD_W-1:0]    coord_z,
  input  logic [INVAL_W-1:0]    voxel_value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [EW-1:0]         push_entry
);

  localparam int SZW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0]     step_i, step_j, step_k, origin;
  logic [3*SIZE_FW-1:0] vol_size;
  logic                 nearest;

  front_state_t state, state_next;
  logic [1:0]   ax;
  logic         it_mode;
  logic [COORD_W-1:0] it_x, it_y, it_z;
  logic [VOXEL_BITS-1:0] it_v;
  logic signed [PW-1:0] p_reg [3];

  logic signed [PW-1:0] p_calc;
  logic [DW-1:0]        base [3];
  logic [FRAC_BITS-1:0] frac [3];
  logic                 outside;
  logic                 wr_outside;
  kind_t                kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_i   <= STEP_I_RST;
      step_j   <= STEP_J_RST;
      step_k   <= STEP_K_RST;
      origin   <= '0;
      vol_size <= SIZE_RST;
      nearest  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEP_I:  step_i   <= cfg_data;
        REG_STEP_J:  step_j   <= cfg_data;
        REG_STEP_K:  step_k   <= cfg_data;
        REG_ORIGIN:  origin   <= cfg_data;
        REG_SIZE:    vol_size <= cfg_data[3*SIZE_FW-1:0];
        REG_NEAREST: nearest  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one axis per cycle: offset plus three coordinate products
  always_comb begin
    logic signed [PW-1:0] ex, ey, ez;
    ex = PW'($signed({1'b0, it_x}));
    ey = PW'($signed({1'b0, it_y}));
    ez = PW'($signed({1'b0, it_z}));
    p_calc = PW'(field_sel(origin, ax))
           + ex * PW'(field_sel(step_i, ax))
           + ey * PW'(field_sel(step_j, ax))
           + ez * PW'(field_sel(step_k, ax));
  end

  always_comb begin
    logic [SIZE_FW-1:0] sf;
    logic [SZW-1:0]     s;
    logic [PW-1:0]      lim;
    logic [PW-1:0]      up;
    logic [PW-1:0]      rnd;
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sf  = vol_size[a*SIZE_FW +: SIZE_FW];
      s   = (SZW'(sf) > SZW'(MAX_DIM) || sf > SIZE_FW'(MAX_DIM > 127 ? 127 : MAX_DIM))
            ? SZW'(MAX_DIM) : SZW'(sf);
      lim = (PW'(s) - PW'(1)) << FRAC_BITS;
      up  = p_reg[a];
      rnd = up + (PW'(1) << (FRAC_BITS - 1));
      if (s < SZW'(2) || p_reg[a] < 0 || up >= lim) outside = 1'b1;
      base[a] = nearest ? rnd[FRAC_BITS +: DW] : up[FRAC_BITS +: DW];
      frac[a] = up[FRAC_BITS-1:0];
    end
  end

  assign wr_outside = ({1'b0, it_x} >= 9'(MAX_DIM)) || ({1'b0, it_y} >= 9'(MAX_DIM))
                   || ({1'b0, it_z} >= 9'(MAX_DIM));

  always_comb begin
    if (!it_mode)     kind = K_WRITE;
    else if (outside) kind = K_OUT;
    else if (nearest) kind = K_NEAR;
    else              kind = K_TRI;
  end

  always_comb begin
    if (kind == K_WRITE) begin
      push_entry = {kind, it_v, {3*FRAC_BITS{1'b0}},
                    it_z[DW-1:0], it_y[DW-1:0], it_x[DW-1:0]};
    end else begin
      push_entry = {kind, it_v, frac[2], frac[1], frac[0], base[2], base[1], base[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push_valid = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = mode ? F_CALC : F_PUSH;
      end
      F_CALC: begin
        if (ax == 2'd2) state_next = F_PUSH;
      end
      F_PUSH: begin
        push_valid = !(!it_mode && wr_outside);
        if (!push_valid || push_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      it_mode <= mode;
      it_x    <= coord_x;
      it_y    <= coord_y;
      it_z    <= coord_z;
      it_v    <= VOXEL_BITS'(voxel_value);
      ax      <= 2'd0;
    end else if (state == F_CALC) begin
      p_reg[ax] <= p_calc;
      ax        <= ax + 2'd1;
    end
  end

endmodule

### rtl/avr_queue.sv
module avr_queue
  import avr_pkg::*;
#(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [EW-1:0] push_entry,
  output logic          pop_valid,
  input  logic          pop,
  output logic [EW-1:0] pop_entry
);

  logic [EW-1:0] slot [2];
  logic          wptr, rptr;
  logic [1:0]    count;
  logic          do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slot[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop)  rptr <= !rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wptr] <= push_entry;
  end

endmodule

### rtl/avr_back.sv
module avr_back
  import avr_pkg::*;
#(
  parameter int VOXEL_BITS = 16,
  parameter int FRAC_BITS  = 11,
  parameter int DW         = 6,
  parameter int EW         = 2 + VOXEL_BITS + 3*FRAC_BITS + 3*DW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop,
  input  logic [EW-1:0]    pop_entry,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] sample_value,
  output logic             in_range
);

  localparam int AW    = 3 * DW;
  localparam int DEPTH = 1 << AW;
  localparam int A_W   = VOXEL_BITS + FRAC_BITS;
  localparam int B_W   = VOXEL_BITS + 2*FRAC_BITS;
  localparam int C_W   = VOXEL_BITS + 3*FRAC_BITS;
  localparam int SH    = 3*FRAC_BITS - 8;
  localparam int SW    = VOXEL_BITS + 8;
  localparam int F_OFS = 3*DW;
  localparam int V_OFS = 3*DW + 3*FRAC_BITS;
  localparam int K_OFS = V_OFS + VOXEL_BITS;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [VOXEL_BITS-1:0] store [DEPTH];

  back_state_t state, state_next;
  kind_t       kind;
  logic [DW-1:0] bx, by, bz;
  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic [VOXEL_BITS-1:0] wdata;
  logic [2:0] n;

  logic rd_en, rd_vld;
  logic [2:0] rd_idx;
  logic [VOXEL_BITS-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [A_W-1:0] a_acc;
  logic [B_W-1:0] b_acc;
  logic [C_W-1:0] c_acc;
  logic a_vld, b_vld, c_vld;
  logic [2:0] a_idx, b_idx;
  logic [FRAC_BITS:0] wx, wy, wz;

  logic [SW-1:0] res_pre;
  logic [OUT_W-1:0] res_sat;
  logic [OUT_W-1:0] res_val;
  logic res_rng;
  logic out_load;
  logic done;

  always_comb begin
    rd_addr = {(n[2] ? bz + DW'(1) : bz), (n[1] ? by + DW'(1) : by),
               (n[0] ? bx + DW'(1) : bx)};
    if (kind == K_NEAR) rd_addr = {bz, by, bx};
  end

  always_ff @(posedge clk) begin
    if (state == B_WRITE) store[{bz, by, bx}] <= wdata;
    if (rd_en) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind  <= kind_t'(pop_entry[K_OFS +: 2]);
      wdata <= pop_entry[V_OFS +: VOXEL_BITS];
      fz    <= pop_entry[F_OFS + 2*FRAC_BITS +: FRAC_BITS];
      fy    <= pop_entry[F_OFS + FRAC_BITS +: FRAC_BITS];
      fx    <= pop_entry[F_OFS +: FRAC_BITS];
      bz    <= pop_entry[2*DW +: DW];
      by    <= pop_entry[DW +: DW];
      bx    <= pop_entry[DW-1:0];
      n     <= 3'd0;
    end else if (rd_en) begin
      n <= n + 3'd1;
    end
  end

  // blend pipeline: x pairs, then y pairs, then z pair
  assign wx = rd_idx[0] ? (FRAC_BITS+1)'(fx) : ONE - (FRAC_BITS+1)'(fx);
  assign wy = a_idx[1]  ? (FRAC_BITS+1)'(fy) : ONE - (FRAC_BITS+1)'(fy);
  assign wz = b_idx[2]  ? (FRAC_BITS+1)'(fz) : ONE - (FRAC_BITS+1)'(fz);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      c_vld  <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      a_vld  <= rd_vld && kind == K_TRI && rd_idx[0];
      b_vld  <= a_vld && a_idx[1];
      c_vld  <= b_vld && b_idx[2];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= n;
    if (rd_vld) begin
      a_acc <= (rd_idx[0] ? a_acc : '0) + A_W'(rd_data) * A_W'(wx);
      a_idx <= rd_idx;
    end
    if (a_vld) begin
      b_acc <= (a_idx[1] ? b_acc : '0) + B_W'(a_acc) * B_W'(wy);
      b_idx <= a_idx;
    end
    if (b_vld) begin
      c_acc <= (b_idx[2] ? c_acc : '0) + C_W'(b_acc) * C_W'(wz);
    end
  end

  always_comb begin
    logic [SW+OUT_W:0] wide;
    res_pre = (kind == K_NEAR) ? {rd_data, 8'd0} : c_acc[C_W-1:SH];
    wide    = (SW+OUT_W+1)'(res_pre);
    res_sat = (wide > (SW+OUT_W+1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(res_pre);
  end

  assign done = (kind == K_NEAR) ? rd_vld : c_vld;

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      res_val <= '0;
      res_rng <= 1'b0;
    end else if (state == B_WAIT && done) begin
      res_val <= res_sat;
      res_rng <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          pop = 1'b1;
          unique case (kind_t'(pop_entry[K_OFS +: 2]))
            K_WRITE: state_next = B_WRITE;
            K_OUT:   state_next = B_DONE;
            default: state_next = B_READ;
          endcase
        end
      end
      B_WRITE: state_next = B_IDLE;
      B_READ: begin
        rd_en = 1'b1;
        if (kind == K_NEAR || n == 3'd7) state_next = B_WAIT;
      end
      B_WAIT: begin
        if (done) state_next = B_DONE;
      end
      B_DONE: begin
        out_load = !out_valid || !out_stall;
        if (out_load) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_value <= res_val;
      in_range     <= res_rng;
    end
  end

  a_done_held: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && out_valid && out_stall) |=> state == B_DONE)
    else $error("result dropped while output stalled");

  a_blend_wait: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> (state == B_WAIT && kind == K_TRI))
    else $error("blend finished outside of wait");

  a_read_owner: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == B_READ || state == B_WAIT))
    else $error("store read returned with no sample in flight");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == B_IDLE)
    else $error("queue popped while busy");

endmodule

### rtl/affine_volume_resampler_unit.sv
// Channel   | Signals                                            | Direction
// ----------+----------------------------------------------------+----------
// input     | in_valid, in_stall, mode, coord_x/y/z, voxel_value | item in
// output    | out_valid, out_stall, sample_value, in_range       | item out
// config    | cfg_write, cfg_index, cfg_data                     | write only
//
// Front: takes an item, does the position math axis by axis in F_CALC, then queues it.
// Back: write via B_WRITE, outside straight to B_DONE, nearest with one store read,
// trilinear with eight reads of the single-port voxel store and a three-stage blend.
// Reset (rst, synchronous) restores the register defaults; the store is not cleared.
// A two-entry queue parts front and back; the result register holds under out_stall.
module affine_volume_resampler_unit
  import avr_pkg::*;
#(
  parameter int MAX_DIM    = 64,
  parameter int VOXEL_BITS = 16,
  parameter int FRAC_BITS  = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic [INVAL_W-1:0] voxel_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   sample_value,
  output logic               in_range
);

  // per-axis address bits; the store is addressed as {z, y, x}
  localparam int DW = $clog2(MAX_DIM);
  localparam int EW = 2 + VOXEL_BITS + 3*FRAC_BITS + 3*DW;

  logic          push_valid, push_ready;
  logic [EW-1:0] push_entry;
  logic          pop_valid, pop;
  logic [EW-1:0] pop_entry;

  // classify: write, outside, nearest or trilinear; work out base and fraction
  avr_front #(
    .MAX_DIM(MAX_DIM), .VOXEL_BITS(VOXEL_BITS), .FRAC_BITS(FRAC_BITS), .DW(DW), .EW(EW)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .voxel_value(voxel_value),
    .push_valid(push_valid), .push_ready(push_ready), .push_entry(push_entry)
  );

  // hold classified items in order so front and back stall on their own
  avr_queue #(.EW(EW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_entry(push_entry),
    .pop_valid(pop_valid), .pop(pop), .pop_entry(pop_entry)
  );

  // store writes, voxel reads, blend and result register
  avr_back #(
    .VOXEL_BITS(VOXEL_BITS), .FRAC_BITS(FRAC_BITS), .DW(DW), .EW(EW)
  ) u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop(pop), .pop_entry(pop_entry),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_value(sample_value), .in_range(in_range)
  );

endmodule
